/* design/sorted_value_list_core_defines.svh */
// Assertion macros shared by the sorted value list checker.
`ifndef SORTED_VALUE_LIST_CORE_DEFINES_SVH
`define SORTED_VALUE_LIST_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SVL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted value list check failed");

// Next-cycle implication, checked outside reset.
`define SVL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted value list check failed");

`endif

/* design/svl_pkg.sv */
// Shared constants, codes and types of the sorted value list.
`timescale 1ns / 1ps
package svl_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VAL_W   = 32;
  localparam int ENTRY_W = 5;

  // Opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_PEEK   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // Broadcast control to every cell
  typedef struct packed {
    logic ins;      // insert value at its sorted place
    logic del_all;  // pop: every cell takes its right neighbor
    logic del_ge;   // remove: cells not below value take right neighbor
    val_t value;
  } cell_ctrl_t;

  // One entry as passed between neighbors
  typedef struct packed {
    logic valid;
    val_t data;
  } cell_link_t;

endpackage

/* design/svl_cell.sv */
// One storage cell of the sorted chain: compare against the operand and shift.
`timescale 1ns / 1ps
module svl_cell (
  input  logic               clk,
  input  logic               rst,
  input  svl_pkg::cell_ctrl_t ctrl,
  input  logic               prev_lt,
  input  svl_pkg::cell_link_t from_prev,
  input  svl_pkg::cell_link_t from_next,
  output svl_pkg::cell_link_t cur,
  output svl_pkg::cell_link_t cur_next,
  output logic               lt,
  output logic               hit
);
  import svl_pkg::*;

  logic valid;
  val_t data;
  logic valid_next;
  val_t data_next;

  // Local compares; the list is sorted, so lt is true for a prefix of cells
  assign lt  = valid && (data < ctrl.value);
  // First equal entry: every entry in front of it is smaller
  assign hit = valid && (data == ctrl.value) && prev_lt;

  // Next entry
  always_comb begin
    valid_next = valid;
    data_next  = data;
    if (ctrl.ins) begin
      if (!lt) begin
        if (prev_lt) begin
          valid_next = 1'b1;
          data_next  = ctrl.value;
        end else begin
          valid_next = from_prev.valid;
          data_next  = from_prev.data;
        end
      end
    end else if (ctrl.del_all || (ctrl.del_ge && !lt)) begin
      valid_next = from_next.valid;
      data_next  = from_next.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign cur.valid      = valid;
  assign cur.data       = data;
  assign cur_next.valid = valid_next;
  assign cur_next.data  = data_next;

endmodule

/* design/sorted_value_list_core.sv */
// Sorted value list: a chain of compare-and-shift cells with a result register.
// A result is shown in the cycle after its input transfer.
// Throughput: one item per cycle while results are taken; every cell compares
// and shifts in parallel for insert, remove, pop and peek alike.
// Reset clears the cell valid bits, the count and the result valid flag at once;
// there is no clearing pass and items are taken in the first cycle after reset.
`timescale 1ns / 1ps
module sorted_value_list_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       opcode,
  input  logic signed [svl_pkg::VAL_W-1:0] value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [svl_pkg::VAL_W-1:0] smallest_value,
  output logic                             is_empty,
  output logic [svl_pkg::ENTRY_W-1:0]      entry_count,
  output logic [1:0]                       status
);
  import svl_pkg::*;

  cell_ctrl_t       ctrl;
  cell_link_t       cur      [DEPTH];
  cell_link_t       cur_next [DEPTH];
  cell_link_t       left_in  [DEPTH];
  cell_link_t       right_in [DEPTH];
  logic [DEPTH-1:0] lt_vec;
  logic [DEPTH-1:0] hit_vec;
  logic [DEPTH-1:0] prev_lt_vec;

  cnt_t       count;
  cnt_t       count_next;
  logic       in_xfer;
  logic       found;
  logic       full;
  logic       empty;
  logic [1:0] status_next;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign full     = (count == cnt_t'(DEPTH));
  assign empty    = (count == '0);
  assign found    = |hit_vec;

  // Decode the operation and its status
  always_comb begin
    ctrl.ins     = 1'b0;
    ctrl.del_all = 1'b0;
    ctrl.del_ge  = 1'b0;
    ctrl.value   = value;
    count_next   = count;
    status_next  = ST_OK;
    unique case (opcode)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.ins   = in_xfer;
          count_next = count + cnt_t'(1);
        end
      end
      OP_REMOVE: begin
        if (found) begin
          ctrl.del_ge = in_xfer;
          count_next  = count - cnt_t'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      OP_POP: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctrl.del_all = in_xfer;
          count_next   = count - cnt_t'(1);
        end
      end
      OP_PEEK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_lt_vec[i] = 1'b1;
      assign left_in[i]     = '0;
    end else begin : g_body
      assign prev_lt_vec[i] = lt_vec[i-1];
      assign left_in[i]     = cur[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_in[i] = '0;
    end else begin : g_mid
      assign right_in[i] = cur[i+1];
    end

    svl_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .prev_lt   (prev_lt_vec[i]),
      .from_prev (left_in[i]),
      .from_next (right_in[i]),
      .cur       (cur[i]),
      .cur_next  (cur_next[i]),
      .lt        (lt_vec[i]),
      .hit       (hit_vec[i])
    );
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_xfer) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      smallest_value <= cur_next[0].valid ? cur_next[0].data : '0;
      is_empty       <= (count_next == '0);
      entry_count    <= ENTRY_W'(count_next);
      status         <= status_next;
    end
  end

endmodule

/* design/svl_checker.sv */
// Port-level checks of the sorted value list, bound to the top level.
`timescale 1ns / 1ps
`include "sorted_value_list_core_defines.svh"
module svl_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [svl_pkg::VAL_W-1:0] smallest_value,
  input logic                             is_empty,
  input logic [1:0]                       status
);
  import svl_pkg::*;

  // An empty list reports zero and can never be full
  `SVL_ASSERT_NOW(a_empty_zero, out_valid && is_empty, smallest_value == '0 && status != ST_FULL)
  // A full refusal leaves entries in place
  `SVL_ASSERT_NOW(a_full_nonempty, out_valid && status == ST_FULL, !is_empty)
  // An empty status only comes from an empty list
  `SVL_ASSERT_NOW(a_empty_status, out_valid && status == ST_EMPTY, is_empty)
  // A stalled result holds
  `SVL_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(smallest_value) && $stable(status))

endmodule

bind sorted_value_list_core svl_checker u_svl_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .smallest_value (smallest_value),
  .is_empty       (is_empty),
  .status         (status)
);
